[hdl/qtp_pkg.sv]
// ============================================================================
// qtp_pkg: shared definitions for the quintic trajectory point block
// Widths, shape constants, phase codes and the sideband structs that
// travel through the pipeline next to the arithmetic.
// ============================================================================
package qtp_pkg;

    // fixed-point widths
    localparam int POS_W  = 32;          // Q8.24 positions, velocity, acceleration
    localparam int DUR_W  = 31;          // unsigned Q15.16 move time
    localparam int FRAC_W = 32;          // Q1.31 normalized time and its powers
    localparam int AD_W   = 33;          // magnitude of end minus start
    localparam int SHP_W  = 31;          // velocity and acceleration shape magnitudes
    localparam int NUM_W  = 64;          // shape times distance products
    localparam int PPR_W  = 65;          // position shape times distance
    localparam int POLY_W = 40;          // polynomial sums before clamping

    // normalized time divider widths
    localparam int S_NUM_W = 62;
    localparam int S_QUO_W = 32;

    // 1.0 in Q1.31
    localparam logic [FRAC_W-1:0] ONE_Q31 = 32'h8000_0000;

    // polynomial coefficients
    localparam logic [7:0] K6   = 8'd6;
    localparam logic [7:0] K10  = 8'd10;
    localparam logic [7:0] K15  = 8'd15;
    localparam logic [7:0] K60  = 8'd60;
    localparam logic [7:0] K120 = 8'd120;
    localparam logic [7:0] K180 = 8'd180;

    // where the time stamp falls relative to the move
    typedef enum logic [1:0] {
        PHASE_BEFORE = 2'd0,
        PHASE_MOVING = 2'd1,
        PHASE_AFTER  = 2'd2
    } phase_t;

    // sideband through the normalized time divider
    typedef struct packed {
        logic [POS_W-1:0] p0;
        logic [POS_W-1:0] pt;
        logic [AD_W-1:0]  ad;
        logic             dneg;
        phase_t           phase;
    } s_tag_t;

    // sideband through the polynomial stages
    typedef struct packed {
        logic [POS_W-1:0] p0;
        logic [POS_W-1:0] pt;
        logic             dneg;
        phase_t           phase;
    } poly_tag_t;

    // sideband through the velocity divider
    typedef struct packed {
        logic [POS_W-1:0] pos;
        phase_t           phase;
        logic             dneg;
        logic [NUM_W-1:0] anum;
        logic             aneg;
    } v_tag_t;

    // sideband through both acceleration dividers
    typedef struct packed {
        logic [POS_W-1:0] pos;
        phase_t           phase;
        logic [POS_W-1:0] vel;
        logic             vsat;
        logic             aneg;
    } a_tag_t;

endpackage

[hdl/qtp_div.sv]
// ============================================================================
// qtp_div: pipelined restoring divider
// One quotient bit per stage, sideband tag carried alongside. The overflow
// flag marks a numerator at or above the divisor times 2^QW, where the
// quotient does not fit.
// ============================================================================
module qtp_div #(
    parameter int DW = qtp_pkg::S_NUM_W,
    parameter int VW = qtp_pkg::DUR_W,
    parameter int QW = qtp_pkg::S_QUO_W,
    parameter int TW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] num,
    input  logic [VW-1:0] den,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          ovf,
    output logic [TW-1:0] out_tag
);

    localparam int RW = VW + QW;
    localparam int CW = ((DW > RW) ? DW : RW) + 1;

    logic          vld_reg [0:QW];
    logic [RW-1:0] rem_reg [0:QW-1];
    logic [QW-1:0] quo_reg [0:QW];
    logic [VW-1:0] den_reg [0:QW-1];
    logic [TW-1:0] tag_reg [0:QW];
    logic          ovf_reg [0:QW];

    logic [CW-1:0] num_ext;
    logic [CW-1:0] lim_ext;

    // entry stage: overflow check against divisor scaled by 2^QW
    assign num_ext = CW'(num);
    assign lim_ext = CW'(den) << QW;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_ext[RW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            tag_reg[0] <= in_tag;
            ovf_reg[0] <= (num_ext >= lim_ext);
        end
    end

    // one trial subtract per stage, most significant quotient bit first
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int B = QW - 1 - k;

        logic [RW:0]   trial;
        logic [QW-1:0] quo_next;
        logic [RW-1:0] rem_next;

        always_comb
        begin
            trial    = {1'b0, rem_reg[k]} - ((RW + 1)'(den_reg[k]) << B);
            quo_next = quo_reg[k];
            rem_next = rem_reg[k];
            if (!trial[RW])
            begin
                quo_next[B] = 1'b1;
                rem_next    = trial[RW-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k+1] <= quo_next;
                tag_reg[k+1] <= tag_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end

        // remainder and divisor are not needed past the last bit
        if (k < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= rem_next;
                    den_reg[k+1] <= den_reg[k];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = quo_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign out_tag   = tag_reg[QW];

endmodule

[hdl/qtp_poly.sv]
// ============================================================================
// qtp_poly: minimum-jerk shape polynomials
// Six stages: powers of the normalized time, the position, velocity and
// acceleration shapes, and their products with the move distance.
// ============================================================================
module qtp_poly #(
    parameter int TW = $bits(qtp_pkg::poly_tag_t)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [qtp_pkg::FRAC_W-1:0] s,
    input  logic [qtp_pkg::AD_W-1:0]   ad,
    input  logic [TW-1:0]             in_tag,
    output logic                      out_valid,
    output logic [qtp_pkg::PPR_W-1:0]  pos_prod,
    output logic [qtp_pkg::NUM_W-1:0]  vel_num,
    output logic [qtp_pkg::NUM_W-1:0]  acc_num,
    output logic                      acc_neg,
    output logic [TW-1:0]             out_tag
);

    import qtp_pkg::*;

    // Q1.31 product, truncated
    function automatic logic [FRAC_W-1:0] q31mul(input logic [FRAC_W-1:0] a,
                                                 input logic [FRAC_W-1:0] b);
        logic [2*FRAC_W-1:0] p;
        p = (2*FRAC_W)'(a) * (2*FRAC_W)'(b);
        return p[2*FRAC_W-2:FRAC_W-1];
    endfunction

    logic [6:1] vld_reg;

    // stage 1
    logic [FRAC_W-1:0] s1_s_reg, s1_s2_reg, s1_u2_reg;
    logic [AD_W-1:0]   s1_ad_reg;
    logic [TW-1:0]     s1_tag_reg;
    // stage 2
    logic [FRAC_W-1:0] s2_s_reg, s2_s2_reg, s2_s3_reg, s2_vp_reg;
    logic [AD_W-1:0]   s2_ad_reg;
    logic [TW-1:0]     s2_tag_reg;
    // stage 3
    logic [FRAC_W-1:0] s3_s_reg, s3_s3_reg, s3_s4_reg;
    logic [SHP_W-1:0]  s3_vsh_reg, s3_aa_reg;
    logic              s3_aneg_reg;
    logic [AD_W-1:0]   s3_ad_reg;
    logic [TW-1:0]     s3_tag_reg;
    // stage 4
    logic [FRAC_W-1:0] s4_s3_reg, s4_s4_reg, s4_s5_reg;
    logic [SHP_W-1:0]  s4_aa_reg;
    logic              s4_aneg_reg;
    logic [NUM_W-1:0]  s4_vnum_reg;
    logic [AD_W-1:0]   s4_ad_reg;
    logic [TW-1:0]     s4_tag_reg;
    // stage 5
    logic [FRAC_W-1:0] s5_p_reg;
    logic              s5_aneg_reg;
    logic [NUM_W-1:0]  s5_vnum_reg, s5_anum_reg;
    logic [AD_W-1:0]   s5_ad_reg;
    logic [TW-1:0]     s5_tag_reg;
    // stage 6
    logic [PPR_W-1:0]  s6_pprod_reg;
    logic              s6_aneg_reg;
    logic [NUM_W-1:0]  s6_vnum_reg, s6_anum_reg;
    logic [TW-1:0]     s6_tag_reg;

    logic [FRAC_W-1:0] u;
    logic [FRAC_W+3:0] vsh_wide;
    logic [POLY_W-1:0] a_pos, a_neg, a_mag;
    logic [POLY_W-1:0] p_pos, p_neg, p_diff;
    logic [FRAC_W-1:0] p_next;

    // complement of normalized time
    assign u = ONE_Q31 - s;

    // velocity shape 15 * s^2 * (1-s)^2
    assign vsh_wide = {s2_vp_reg, 4'b0000} - (FRAC_W + 4)'(s2_vp_reg);

    // acceleration shape 60s - 180s^2 + 120s^3 as sign and magnitude
    always_comb
    begin
        a_pos = POLY_W'(s2_s_reg) * POLY_W'(K60) + POLY_W'(s2_s3_reg) * POLY_W'(K120);
        a_neg = POLY_W'(s2_s2_reg) * POLY_W'(K180);
        a_mag = (a_pos < a_neg) ? (a_neg - a_pos) : (a_pos - a_neg);
    end

    // position shape 10s^3 - 15s^4 + 6s^5 clamped to [0, 1]
    always_comb
    begin
        p_pos  = POLY_W'(s4_s3_reg) * POLY_W'(K10) + POLY_W'(s4_s5_reg) * POLY_W'(K6);
        p_neg  = POLY_W'(s4_s4_reg) * POLY_W'(K15);
        p_diff = p_pos - p_neg;
        if (p_pos <= p_neg)
        begin
            p_next = '0;
        end
        else if (p_diff > POLY_W'(ONE_Q31))
        begin
            p_next = ONE_Q31;
        end
        else
        begin
            p_next = p_diff[FRAC_W-1:0];
        end
    end

    // valid shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:1], in_valid};
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_s_reg     <= s;
            s1_s2_reg    <= q31mul(s, s);
            s1_u2_reg    <= q31mul(u, u);
            s1_ad_reg    <= ad;
            s1_tag_reg   <= in_tag;

            s2_s_reg     <= s1_s_reg;
            s2_s2_reg    <= s1_s2_reg;
            s2_s3_reg    <= q31mul(s1_s2_reg, s1_s_reg);
            s2_vp_reg    <= q31mul(s1_s2_reg, s1_u2_reg);
            s2_ad_reg    <= s1_ad_reg;
            s2_tag_reg   <= s1_tag_reg;

            s3_s_reg     <= s2_s_reg;
            s3_s3_reg    <= s2_s3_reg;
            s3_s4_reg    <= q31mul(s2_s3_reg, s2_s_reg);
            s3_vsh_reg   <= vsh_wide[SHP_W-1:0];
            s3_aa_reg    <= a_mag[SHP_W+2:3];
            s3_aneg_reg  <= (a_pos < a_neg);
            s3_ad_reg    <= s2_ad_reg;
            s3_tag_reg   <= s2_tag_reg;

            s4_s3_reg    <= s3_s3_reg;
            s4_s4_reg    <= s3_s4_reg;
            s4_s5_reg    <= q31mul(s3_s4_reg, s3_s_reg);
            s4_aa_reg    <= s3_aa_reg;
            s4_aneg_reg  <= s3_aneg_reg;
            s4_vnum_reg  <= NUM_W'(s3_ad_reg) * NUM_W'(s3_vsh_reg);
            s4_ad_reg    <= s3_ad_reg;
            s4_tag_reg   <= s3_tag_reg;

            s5_p_reg     <= p_next;
            s5_aneg_reg  <= s4_aneg_reg;
            s5_vnum_reg  <= s4_vnum_reg;
            s5_anum_reg  <= NUM_W'(s4_ad_reg) * NUM_W'(s4_aa_reg);
            s5_ad_reg    <= s4_ad_reg;
            s5_tag_reg   <= s4_tag_reg;

            s6_pprod_reg <= PPR_W'(s5_ad_reg) * PPR_W'(s5_p_reg);
            s6_aneg_reg  <= s5_aneg_reg;
            s6_vnum_reg  <= s5_vnum_reg;
            s6_anum_reg  <= s5_anum_reg;
            s6_tag_reg   <= s5_tag_reg;
        end
    end

    assign out_valid = vld_reg[6];
    assign pos_prod  = s6_pprod_reg;
    assign vel_num   = s6_vnum_reg;
    assign acc_num   = s6_anum_reg;
    assign acc_neg   = s6_aneg_reg;
    assign out_tag   = s6_tag_reg;

endmodule

[hdl/quintic_trajectory_point_top.sv]
// ============================================================================
// quintic_trajectory_point_top: minimum-jerk setpoint for one joint
// Position, velocity and acceleration of the quintic profile at one time
// stamp, for a move time held in the duration register.
//
//   channel   signals                              direction
//   request   in_valid / in_ready, 3 fields         in
//   result    out_valid / out_ready, 5 fields       out
//   config    cfg_valid / cfg_ready, cfg_data       in
//
// One request enters per cycle while the pipeline is not held; each gives
// one result after passing through the bit-serial pipelines of the time divider (33 stages), the
// velocity divider (34) and the two acceleration dividers (65 and 34).
// Reset empties the pipeline and loads the duration with 4.5 s.
// The whole pipeline holds only while its last stage and the output
// register are both full and the result is not taken.
// ============================================================================
module quintic_trajectory_point_top (
    input  logic        clk,
    input  logic        rst_n,
    // config
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    // request
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] start_position,
    input  logic [31:0] end_position,
    input  logic [31:0] time_now,
    // result
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] position_out,
    output logic [31:0] velocity_out,
    output logic [31:0] acceleration_out,
    output logic [1:0]  phase,
    output logic        saturated
);

    import qtp_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] value;
        logic             sat;
    } sat_res_t;

    // sign a magnitude and clip to signed 32 bits
    function automatic sat_res_t sat_apply(input logic neg, input logic big,
                                           input logic [POS_W:0] mag);
        sat_res_t r;
        r.sat   = 1'b0;
        r.value = '0;
        if (!neg)
        begin
            if (big || mag > (POS_W + 1)'(32'h7FFF_FFFF))
            begin
                r.sat   = 1'b1;
                r.value = 32'h7FFF_FFFF;
            end
            else
            begin
                r.value = mag[POS_W-1:0];
            end
        end
        else
        begin
            if (big || mag > (POS_W + 1)'(32'h8000_0000))
            begin
                r.sat   = 1'b1;
                r.value = 32'h8000_0000;
            end
            else
            begin
                r.value = 32'd0 - mag[POS_W-1:0];
            end
        end
        return r;
    endfunction

    logic [DUR_W-1:0] dur_reg;
    logic [DUR_W-1:0] t_eff;
    logic             en;

    // request side
    logic [AD_W-1:0]  diff;
    s_tag_t           s_in_tag, s_out_tag;
    logic             s_valid, s_ovf;
    logic [FRAC_W-1:0] s_val;

    // polynomial side
    poly_tag_t        p_in_tag, p_out_tag;
    logic             p_valid, p_aneg;
    logic [PPR_W-1:0] p_prod;
    logic [NUM_W-1:0] p_vnum, p_anum;
    logic [PPR_W:0]   pm_sum;
    logic [POS_W-1:0] pm, pos_move;

    // velocity divider
    v_tag_t           v_in_tag, v_out_tag;
    logic             v_valid, v_ovf;
    logic [POS_W:0]   v_quo;
    sat_res_t         v_res;

    // acceleration dividers
    a_tag_t           a1_in_tag, a1_out_tag, a2_out_tag;
    logic             a1_valid, a1_ovf, a2_valid, a2_ovf;
    logic [NUM_W-1:0] a1_quo;
    logic [POS_W:0]   a2_quo;
    sat_res_t         a_res;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] pos_out_reg, vel_out_reg, acc_out_reg;
    phase_t           phase_out_reg;
    logic             sat_out_reg;

    // duration register, zero treated as one tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg <= 31'd294912;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dur_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign t_eff     = (dur_reg == '0) ? DUR_W'(1) : dur_reg;

    // pipeline advance
    assign en       = !a2_valid || !out_valid_reg || out_ready;
    assign in_ready = en;

    // distance, its magnitude, and the phase of the time stamp
    always_comb
    begin
        diff           = {end_position[31], end_position} -
                         {start_position[31], start_position};
        s_in_tag.p0    = start_position;
        s_in_tag.pt    = end_position;
        s_in_tag.dneg  = diff[AD_W-1];
        s_in_tag.ad    = diff[AD_W-1] ? (AD_W'(0) - diff) : diff;
        if (time_now[31])
        begin
            s_in_tag.phase = PHASE_BEFORE;
        end
        else if (time_now[30:0] > t_eff)
        begin
            s_in_tag.phase = PHASE_AFTER;
        end
        else
        begin
            s_in_tag.phase = PHASE_MOVING;
        end
    end

    // normalized time s = t * 2^31 / T
    qtp_div #(
        .DW (S_NUM_W),
        .VW (DUR_W),
        .QW (S_QUO_W),
        .TW ($bits(s_tag_t))
    ) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .num       ({time_now[30:0], 31'd0}),
        .den       (t_eff),
        .in_tag    (s_in_tag),
        .out_valid (s_valid),
        .quo       (s_val),
        .ovf       (s_ovf),
        .out_tag   (s_out_tag)
    );

    assign p_in_tag.p0    = s_out_tag.p0;
    assign p_in_tag.pt    = s_out_tag.pt;
    assign p_in_tag.dneg  = s_out_tag.dneg;
    assign p_in_tag.phase = s_out_tag.phase;

    // shape polynomials and distance products
    qtp_poly #(
        .TW ($bits(poly_tag_t))
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .s         (s_val),
        .ad        (s_out_tag.ad),
        .in_tag    (p_in_tag),
        .out_valid (p_valid),
        .pos_prod  (p_prod),
        .vel_num   (p_vnum),
        .acc_num   (p_anum),
        .acc_neg   (p_aneg),
        .out_tag   (p_out_tag)
    );

    // rounded position offset and the position for each phase
    always_comb
    begin
        pm_sum   = (PPR_W + 1)'(p_prod) + (PPR_W + 1)'(64'h4000_0000);
        pm       = pm_sum[POS_W+30:31];
        pos_move = p_out_tag.dneg ? (p_out_tag.p0 - pm) : (p_out_tag.p0 + pm);
        case (p_out_tag.phase)
            PHASE_BEFORE: v_in_tag.pos = p_out_tag.p0;
            PHASE_AFTER:  v_in_tag.pos = p_out_tag.pt;
            default:      v_in_tag.pos = pos_move;
        endcase
        v_in_tag.phase = p_out_tag.phase;
        v_in_tag.dneg  = p_out_tag.dneg;
        v_in_tag.anum  = p_anum;
        v_in_tag.aneg  = p_aneg;
    end

    // velocity magnitude |d| * V / (T * 2^14)
    qtp_div #(
        .DW (NUM_W),
        .VW (DUR_W + 14),
        .QW (POS_W + 1),
        .TW ($bits(v_tag_t))
    ) u_div_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .num       (p_vnum),
        .den       ({t_eff, 14'd0}),
        .in_tag    (v_in_tag),
        .out_valid (v_valid),
        .quo       (v_quo),
        .ovf       (v_ovf),
        .out_tag   (v_out_tag)
    );

    always_comb
    begin
        v_res           = sat_apply(v_out_tag.dneg, v_ovf, v_quo);
        a1_in_tag.pos   = v_out_tag.pos;
        a1_in_tag.phase = v_out_tag.phase;
        a1_in_tag.vel   = v_res.value;
        a1_in_tag.vsat  = v_res.sat;
        a1_in_tag.aneg  = v_out_tag.dneg ^ v_out_tag.aneg;
    end

    // first acceleration step |d| * a / T
    qtp_div #(
        .DW (NUM_W),
        .VW (DUR_W),
        .QW (NUM_W),
        .TW ($bits(a_tag_t))
    ) u_div_a1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_valid),
        .num       (v_out_tag.anum),
        .den       (t_eff),
        .in_tag    (a1_in_tag),
        .out_valid (a1_valid),
        .quo       (a1_quo),
        .ovf       (a1_ovf),
        .out_tag   (a1_out_tag)
    );

    // second acceleration step 16 * q / T
    qtp_div #(
        .DW (NUM_W + 4),
        .VW (DUR_W),
        .QW (POS_W + 1),
        .TW ($bits(a_tag_t))
    ) u_div_a2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a1_valid),
        .num       ({a1_quo, 4'd0}),
        .den       (t_eff),
        .in_tag    (a1_out_tag),
        .out_valid (a2_valid),
        .quo       (a2_quo),
        .ovf       (a2_ovf),
        .out_tag   (a2_out_tag)
    );

    assign a_res = sat_apply(a2_out_tag.aneg, a2_ovf, a2_quo);

    // output register valid
    always_comb
    begin
        if (a2_valid && en)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, zero rates outside the move
    always_ff @(posedge clk)
    begin
        if (a2_valid && en)
        begin
            pos_out_reg   <= a2_out_tag.pos;
            phase_out_reg <= a2_out_tag.phase;
            if (a2_out_tag.phase == PHASE_MOVING)
            begin
                vel_out_reg <= a2_out_tag.vel;
                acc_out_reg <= a_res.value;
                sat_out_reg <= a2_out_tag.vsat | a_res.sat;
            end
            else
            begin
                vel_out_reg <= '0;
                acc_out_reg <= '0;
                sat_out_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign position_out     = pos_out_reg;
    assign velocity_out     = vel_out_reg;
    assign acceleration_out = acc_out_reg;
    assign phase            = phase_out_reg;
    assign saturated        = sat_out_reg;

    // a moving time stamp never exceeds the duration, so s fits
    a_s_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && s_out_tag.phase == PHASE_MOVING) |-> !s_ovf)
        else $error("normalized time overflowed");

    // the first acceleration quotient always fits in 64 bits
    a_q1_fits: assert property (@(posedge clk) disable iff (!rst_n)
        a1_valid |-> !a1_ovf)
        else $error("acceleration quotient overflowed");

    // outside the move the rates are zero and nothing is clipped
    a_idle_rates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase != PHASE_MOVING) |->
            (velocity_out == '0 && acceleration_out == '0 && !saturated))
        else $error("nonzero rate outside the move");

    // a stalled result is not overwritten
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(position_out)
            && $stable(acceleration_out)))
        else $error("stalled result changed");

endmodule
